>>> rtl/brbc_pkg.sv
`timescale 1ns / 1ps
package brbc_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam int unsigned COUNT_W = 35;
    localparam int unsigned SIZE_W = 32;

    typedef enum logic [1:0] {
        OP_ZERO,
        OP_START,
        OP_DATA
    } t_op_kind;

    typedef enum logic {
        PH_IDLE,
        PH_COUNT
    } t_phase;

    typedef struct packed {
        t_op_kind          kind;
        logic [SIZE_W-1:0] first_idx;
        logic [SIZE_W-1:0] last_idx;
        logic [7:0]        first_mask;
        logic [7:0]        last_mask;
        logic [7:0]        data;
        logic              last;
    } t_op;

endpackage

>>> rtl/brbc_front.sv
`timescale 1ns / 1ps
module brbc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_req_type,
    input  logic signed [63:0]  i_bound_lo,
    input  logic signed [63:0]  i_range_end,
    input  logic                i_unit_is_bit,
    input  logic                i_range_given,
    input  logic                i_key_found,
    input  logic [31:0]         i_value_length,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    output logic                o_push,
    output brbc_pkg::t_op       o_op,
    input  logic                i_ready
);

    logic               r_valid;
    logic               n_valid;
    logic               r_req_type;
    logic               r_unit_is_bit;
    logic               r_range_given;
    logic               r_key_found;
    logic [31:0]        r_size;
    logic signed [63:0] r_s;
    logic signed [63:0] r_e;
    logic [7:0]         r_data;
    logic               r_last;

    logic               accept;
    logic [34:0]        len;
    logic signed [63:0] s_norm;
    logic signed [63:0] e_norm;
    logic [63:0]        sb;
    logic [63:0]        eb;
    logic               bad_range;
    brbc_pkg::t_op      op;

    assign o_stall = r_valid && !i_ready;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && i_ready;

    // normalize negative bounds against the length in the chosen unit
    assign len    = i_unit_is_bit ? {i_value_length, 3'b000} : {3'b000, i_value_length};
    assign s_norm = i_bound_lo + (i_bound_lo[63] ? $signed({29'd0, len}) : 64'sd0);
    assign e_norm = i_range_end + (i_range_end[63] ? $signed({29'd0, len}) : 64'sd0);

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type    <= i_req_type;
            r_unit_is_bit <= i_unit_is_bit;
            r_range_given <= i_range_given;
            r_key_found   <= i_key_found;
            r_size        <= i_value_length;
            r_s           <= s_norm;
            r_e           <= e_norm;
            r_data        <= i_data_byte;
            r_last        <= i_last_byte;
        end
    end

    assign sb = r_unit_is_bit ? {3'b000, r_s[63:3]} : r_s;
    assign eb = r_unit_is_bit ? {3'b000, r_e[63:3]} : r_e;
    assign bad_range = r_s[63] || r_e[63] || (r_s > r_e)
                       || (sb >= {32'd0, r_size}) || (eb >= {32'd0, r_size});

    always_comb begin
        op.kind       = brbc_pkg::OP_DATA;
        op.first_idx  = sb[31:0];
        op.last_idx   = eb[31:0];
        op.first_mask = brbc_pkg::BYTE_ONES;
        op.last_mask  = brbc_pkg::BYTE_ONES;
        op.data       = r_data;
        op.last       = r_last;
        if (!r_req_type) begin
            if (!r_key_found) begin
                op.kind = brbc_pkg::OP_ZERO;
            end else if (!r_range_given) begin
                op.first_idx = '0;
                op.last_idx  = r_size - 32'd1;
                op.kind      = (r_size == '0) ? brbc_pkg::OP_ZERO : brbc_pkg::OP_START;
            end else if (bad_range) begin
                op.kind = brbc_pkg::OP_ZERO;
            end else begin
                op.kind = brbc_pkg::OP_START;
                if (r_unit_is_bit) begin
                    op.first_mask = brbc_pkg::BYTE_ONES >> r_s[2:0];
                    op.last_mask  = brbc_pkg::BYTE_ONES << (~r_e[2:0]);
                end
            end
        end
    end

    assign o_op = op;

`ifndef SYNTHESIS
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_s) && $stable(r_req_type)))
        else $error("front stage lost a held word");
`endif

endmodule

>>> rtl/brbc_queue.sv
`timescale 1ns / 1ps
module brbc_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  brbc_pkg::t_op i_op,
    output logic          o_ready,
    output logic          o_valid,
    output brbc_pkg::t_op o_op,
    input  logic          i_pop
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    brbc_pkg::t_op r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [CW-1:0] n_count;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_push && !i_pop)) |-> r_count == CW'($past(r_count) + 1'b1))
        else $error("queue count missed a push");
`endif

endmodule

>>> rtl/brbc_back.sv
`timescale 1ns / 1ps
module brbc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  brbc_pkg::t_op i_q_op,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [34:0]   o_bit_count
);

    brbc_pkg::t_phase r_phase;
    brbc_pkg::t_phase n_phase;
    logic [31:0]      r_pos;
    logic [31:0]      n_pos;
    logic [31:0]      r_first;
    logic [31:0]      n_first;
    logic [31:0]      r_last;
    logic [31:0]      n_last;
    logic [7:0]       r_fmask;
    logic [7:0]       n_fmask;
    logic [7:0]       r_lmask;
    logic [7:0]       n_lmask;
    logic [34:0]      r_count;
    logic [34:0]      n_count;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [34:0]      r_out_count;
    logic [34:0]      n_out_count;

    logic             pop;
    logic             in_range;
    logic [7:0]       masked;
    logic [3:0]       ones;

    function automatic logic [3:0] popcount8(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, b[i]};
        end
        return n;
    endfunction

    assign pop      = i_q_valid && (!r_out_valid || !i_stall);
    assign o_pop    = pop;
    assign in_range = (r_pos >= r_first) && (r_pos <= r_last);
    assign masked   = i_q_op.data
                      & ((r_pos == r_first) ? r_fmask : brbc_pkg::BYTE_ONES)
                      & ((r_pos == r_last) ? r_lmask : brbc_pkg::BYTE_ONES);
    assign ones     = popcount8(masked);

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_first     = r_first;
        n_last      = r_last;
        n_fmask     = r_fmask;
        n_lmask     = r_lmask;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_stall;
        n_out_count = r_out_count;
        if (pop) begin
            case (i_q_op.kind)
                brbc_pkg::OP_ZERO: begin
                    n_phase     = brbc_pkg::PH_IDLE;
                    n_pos       = '0;
                    n_count     = '0;
                    n_fmask     = brbc_pkg::BYTE_ONES;
                    n_lmask     = brbc_pkg::BYTE_ONES;
                    n_out_valid = 1'b1;
                    n_out_count = '0;
                end
                brbc_pkg::OP_START: begin
                    n_phase = brbc_pkg::PH_COUNT;
                    n_pos   = '0;
                    n_count = '0;
                    n_first = i_q_op.first_idx;
                    n_last  = i_q_op.last_idx;
                    n_fmask = i_q_op.first_mask;
                    n_lmask = i_q_op.last_mask;
                end
                brbc_pkg::OP_DATA: begin
                    if (r_phase == brbc_pkg::PH_COUNT) begin
                        if (in_range) begin
                            n_count = r_count + {31'd0, ones};
                        end
                        if (r_pos != '1) begin
                            n_pos = r_pos + 32'd1;
                        end
                        if (i_q_op.last) begin
                            n_phase     = brbc_pkg::PH_IDLE;
                            n_out_valid = 1'b1;
                            n_out_count = n_count;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= brbc_pkg::PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_fmask     <= brbc_pkg::BYTE_ONES;
            r_lmask     <= brbc_pkg::BYTE_ONES;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_first     <= n_first;
            r_last      <= n_last;
            r_fmask     <= n_fmask;
            r_lmask     <= n_lmask;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_count <= n_out_count;
    end

    assign o_valid     = r_out_valid;
    assign o_bit_count = r_out_count;

`ifndef SYNTHESIS
    a_zero_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(pop && i_q_op.kind == brbc_pkg::OP_ZERO))
        |-> (o_valid && o_bit_count == '0))
        else $error("zero reply missing");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(pop && i_q_op.kind == brbc_pkg::OP_DATA && i_q_op.last))
        |-> r_phase == brbc_pkg::PH_IDLE)
        else $error("counter still busy after last byte");
`endif

endmodule

>>> rtl/byte_range_bit_counter_top.sv
`timescale 1ns / 1ps
// Result path: a word that causes a result on o_valid (a header that answers zero, or the
//   data byte marked last) passes the front register, the queue and the output register.
// Throughput: one word per cycle; the front stage and the queue take words
//   while a finished count waits on i_stall, until the queue fills.
// Reset: synchronous, active low; clears the queue and the counter, no clearing pass.
module byte_range_bit_counter_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_req_type,
    input  logic signed [63:0] i_bound_lo,
    input  logic signed [63:0] i_range_end,
    input  logic               i_unit_is_bit,
    input  logic               i_range_given,
    input  logic               i_key_found,
    input  logic [31:0]        i_value_length,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [34:0]        o_bit_count
);

    logic          push;
    logic          q_ready;
    logic          q_valid;
    logic          pop;
    brbc_pkg::t_op push_op;
    brbc_pkg::t_op head_op;

    brbc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_bound_lo     (i_bound_lo),
        .i_range_end    (i_range_end),
        .i_unit_is_bit  (i_unit_is_bit),
        .i_range_given  (i_range_given),
        .i_key_found    (i_key_found),
        .i_value_length (i_value_length),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_push         (push),
        .o_op           (push_op),
        .i_ready        (q_ready)
    );

    brbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_op    (head_op),
        .i_pop   (pop)
    );

    brbc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_op      (head_op),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_bit_count (o_bit_count)
    );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;

    localparam logic REQ_HEADER = 1'b0;
    localparam logic REQ_DATA   = 1'b1;
    localparam int   ITEM_TARGET = 1350;
    localparam int   HOLD_CYCLES = 300;
    localparam int   DRAIN_CYCLES = 8;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   REPORT_LIMIT = 10;

    typedef struct {
        logic               req_type;
        logic signed [63:0] bound_lo;
        logic signed [63:0] range_end;
        logic               unit_is_bit;
        logic               range_given;
        logic               key_found;
        logic [31:0]        value_length;
        logic [7:0]         data_byte;
        logic               last_byte;
    } t_brbc_word;

    class t_bitcount_tracker;
        brbc_pkg::t_phase            phase;
        logic [brbc_pkg::SIZE_W-1:0]  position;
        logic [brbc_pkg::SIZE_W-1:0]  first_idx;
        logic [brbc_pkg::SIZE_W-1:0]  last_idx;
        logic [7:0]                   first_mask;
        logic [7:0]                   last_mask;
        logic [brbc_pkg::COUNT_W-1:0] running;
        logic [brbc_pkg::COUNT_W-1:0] pending_counts[$];
        int                           error_count;

        function new();
            phase       = brbc_pkg::PH_IDLE;
            position    = '0;
            first_idx   = '0;
            last_idx    = '0;
            first_mask  = brbc_pkg::BYTE_ONES;
            last_mask   = brbc_pkg::BYTE_ONES;
            running     = '0;
            error_count = 0;
        endfunction

        function int outstanding();
            return pending_counts.size();
        endfunction

        function void take_word(t_brbc_word w);
            longint      span;
            longint      s_norm;
            longint      e_norm;
            logic [63:0] s_byte;
            logic [63:0] e_byte;
            logic [7:0]  b;
            if (w.req_type == REQ_HEADER) begin
                phase      = brbc_pkg::PH_IDLE;
                running    = '0;
                position   = '0;
                first_mask = brbc_pkg::BYTE_ONES;
                last_mask  = brbc_pkg::BYTE_ONES;
                if (!w.key_found) begin
                    pending_counts.push_back('0);
                    return;
                end
                if (!w.range_given) begin
                    if (w.value_length == 0) begin
                        pending_counts.push_back('0);
                        return;
                    end
                    first_idx = '0;
                    last_idx  = w.value_length - 1;
                    phase     = brbc_pkg::PH_COUNT;
                    return;
                end
                span = w.unit_is_bit ? {29'b0, w.value_length, 3'b0} : {32'b0, w.value_length};
                s_norm = w.bound_lo;
                e_norm = w.range_end;
                if (s_norm < 0) s_norm = s_norm + span;
                if (e_norm < 0) e_norm = e_norm + span;
                if (s_norm < 0 || e_norm < 0 || s_norm > e_norm) begin
                    pending_counts.push_back('0);
                    return;
                end
                s_byte = s_norm;
                e_byte = e_norm;
                if (w.unit_is_bit) begin
                    s_byte = s_byte >> 3;
                    e_byte = e_byte >> 3;
                end
                if (s_byte >= {32'b0, w.value_length} || e_byte >= {32'b0, w.value_length}) begin
                    pending_counts.push_back('0);
                    return;
                end
                if (w.unit_is_bit) begin
                    first_mask = brbc_pkg::BYTE_ONES >> s_norm[2:0];
                    last_mask  = brbc_pkg::BYTE_ONES << (3'd7 - e_norm[2:0]);
                end
                first_idx = s_byte[brbc_pkg::SIZE_W-1:0];
                last_idx  = e_byte[brbc_pkg::SIZE_W-1:0];
                phase     = brbc_pkg::PH_COUNT;
            end else if (phase == brbc_pkg::PH_COUNT) begin
                if (position >= first_idx && position <= last_idx) begin
                    b = w.data_byte;
                    if (position == first_idx) b = b & first_mask;
                    if (position == last_idx) b = b & last_mask;
                    running = running + $countones(b);
                end
                if (position != '1) position = position + 1;
                if (w.last_byte) begin
                    pending_counts.push_back(running);
                    phase = brbc_pkg::PH_IDLE;
                end
            end
        endfunction

        function void match_count(logic [brbc_pkg::COUNT_W-1:0] got);
            logic [brbc_pkg::COUNT_W-1:0] want;
            if (pending_counts.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected bit count %0d with nothing pending", got);
                return;
            end
            want = pending_counts.pop_front();
            if (got !== want) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("bit count mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_req_type;
    logic signed [63:0] i_bound_lo;
    logic signed [63:0] i_range_end;
    logic               i_unit_is_bit;
    logic               i_range_given;
    logic               i_key_found;
    logic [31:0]        i_value_length;
    logic [7:0]         i_data_byte;
    logic               i_last_byte;
    logic               o_valid;
    logic               i_stall;
    logic [34:0]        o_bit_count;

    t_bitcount_tracker tracker = new();
    t_brbc_word        stim_words[$];
    int                counted_items = 0;
    int                words_sent = 0;
    int                hold_from = 0;
    int                sender_idle_pct = 26;
    int                receiver_idle_pct = 67;
    int                cycle_count = 0;

    byte_range_bit_counter_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_bound_lo     (i_bound_lo),
        .i_range_end    (i_range_end),
        .i_unit_is_bit  (i_unit_is_bit),
        .i_range_given  (i_range_given),
        .i_key_found    (i_key_found),
        .i_value_length (i_value_length),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_bit_count    (o_bit_count)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void push_header(input longint rs, input longint re,
                                        input logic bit_unit, input logic given,
                                        input logic key, input logic [31:0] len,
                                        input bit counts);
        t_brbc_word w;
        w.req_type     = REQ_HEADER;
        w.bound_lo     = rs;
        w.range_end    = re;
        w.unit_is_bit  = bit_unit;
        w.range_given  = given;
        w.key_found    = key;
        w.value_length = len;
        w.data_byte    = 8'($urandom);
        w.last_byte    = 1'($urandom_range(0, 1));
        stim_words.push_back(w);
        if (counts) counted_items++;
    endfunction

    function automatic void push_byte(input logic [7:0] d, input logic last, input bit counts);
        t_brbc_word w;
        w.req_type     = REQ_DATA;
        w.bound_lo     = {$urandom, $urandom};
        w.range_end    = {$urandom, $urandom};
        w.unit_is_bit  = 1'($urandom_range(0, 1));
        w.range_given  = 1'($urandom_range(0, 1));
        w.key_found    = 1'($urandom_range(0, 1));
        w.value_length = $urandom;
        w.data_byte    = d;
        w.last_byte    = last;
        stim_words.push_back(w);
        if (counts) counted_items++;
    endfunction

    function automatic void add_random_request();
        int     pick;
        int     len;
        int     span;
        int     s_idx;
        int     e_idx;
        int     nbytes;
        logic   bit_unit;
        logic   given;
        longint s_arg;
        longint e_arg;
        pick = $urandom_range(0, 99);
        if (pick >= 93) begin
            nbytes = $urandom_range(1, 3);
            for (int k = 0; k < nbytes; k++)
                push_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
            return;
        end
        if (pick >= 83) begin
            push_header({$urandom, $urandom}, {$urandom, $urandom},
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        $urandom_range(0, 3) != 0,
                        $urandom_range(0, 1) ? $urandom : $urandom_range(0, 12), 1'b1);
            nbytes = $urandom_range(0, 4);
            for (int k = 0; k < nbytes; k++)
                push_byte(8'($urandom), k == nbytes - 1, 1'b0);
            return;
        end
        bit_unit = 1'($urandom_range(0, 1));
        given    = $urandom_range(0, 3) != 0;
        len      = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 48) : $urandom_range(1, 10);
        if (!given && $urandom_range(0, 9) == 0) len = 0;
        span = bit_unit ? len * 8 : len;
        if (given) begin
            s_idx = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, span - 1);
            e_idx = ($urandom_range(0, 3) == 0) ? span - 1 : $urandom_range(s_idx, span - 1);
            s_arg = $urandom_range(0, 1) ? s_idx - span : s_idx;
            e_arg = $urandom_range(0, 1) ? e_idx - span : e_idx;
        end else begin
            s_arg = {$urandom, $urandom};
            e_arg = {$urandom, $urandom};
        end
        push_header(s_arg, e_arg, bit_unit, given, 1'b1, len, 1'b1);
        if (len == 0) return;
        if (pick < 65) begin
            nbytes = len;
        end else if (pick < 75) begin
            nbytes = len + int'($urandom_range(0, 6)) - 3;
            if (nbytes < 1) nbytes = 1;
        end else begin
            nbytes = $urandom_range(0, len - 1);
        end
        for (int k = 0; k < nbytes; k++)
            push_byte(8'($urandom), pick < 75 && k == nbytes - 1, 1'b1);
    endfunction

    function automatic void build_stimulus();
        // data with no request open
        push_byte(8'hFF, 1'b1, 1'b0);
        // missing key with extreme fields
        push_header(64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000, 1'b1, 1'b1, 1'b0,
                    32'hFFFF_FFFF, 1'b1);
        // empty whole value
        push_header(0, 0, 1'b0, 1'b0, 1'b1, 32'd0, 1'b1);
        // whole value
        push_header(0, 0, 1'b0, 1'b0, 1'b1, 32'd2, 1'b1);
        push_byte(8'hFF, 1'b0, 1'b1);
        push_byte(8'h81, 1'b1, 1'b1);
        // byte range counted back from the end
        push_header(-1, -1, 1'b0, 1'b1, 1'b1, 32'd2, 1'b1);
        push_byte(8'hFF, 1'b0, 1'b1);
        push_byte(8'h0F, 1'b1, 1'b1);
        // bit range inside one byte, both masks
        push_header(3, 5, 1'b1, 1'b1, 1'b1, 32'd1, 1'b1);
        push_byte(8'hFF, 1'b1, 1'b1);
        // start stays negative after normalizing
        push_header(64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1,
                    32'd1, 1'b1);
        // start beyond end
        push_header(5, 2, 1'b0, 1'b1, 1'b1, 32'd8, 1'b1);
        // end byte past the value
        push_header(0, 3, 1'b0, 1'b1, 1'b1, 32'd3, 1'b1);
        // header while counting drops the open request
        push_header(0, -1, 1'b1, 1'b1, 1'b1, 32'd2, 1'b1);
        push_byte(8'h80, 1'b0, 1'b1);
        push_header(0, 0, 1'b0, 1'b0, 1'b1, 32'd1, 1'b1);
        push_byte(8'h7F, 1'b1, 1'b1);
        // last marked early, range within one middle byte
        push_header(9, 14, 1'b1, 1'b1, 1'b1, 32'd4, 1'b1);
        push_byte(8'hFF, 1'b0, 1'b1);
        push_byte(8'hFF, 1'b0, 1'b1);
        push_byte(8'hFF, 1'b1, 1'b1);
        while (counted_items < ITEM_TARGET) add_random_request();
    endfunction

    task automatic send_word(input t_brbc_word w);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= w.req_type;
        i_bound_lo     <= w.bound_lo;
        i_range_end    <= w.range_end;
        i_unit_is_bit  <= w.unit_is_bit;
        i_range_given  <= w.range_given;
        i_key_found    <= w.key_found;
        i_value_length <= w.value_length;
        i_data_byte    <= w.data_byte;
        i_last_byte    <= w.last_byte;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.take_word(w);
        words_sent++;
    endtask

    initial begin
        int total;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_req_type     <= REQ_HEADER;
        i_bound_lo     <= '0;
        i_range_end    <= '0;
        i_unit_is_bit  <= 1'b0;
        i_range_given  <= 1'b0;
        i_key_found    <= 1'b0;
        i_value_length <= '0;
        i_data_byte    <= '0;
        i_last_byte    <= 1'b0;
        build_stimulus();
        total = stim_words.size();
        hold_from = 2 * total / 3 + 10;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < total; i++) begin
            if (i == total / 3) begin
                sender_idle_pct   = 67;
                receiver_idle_pct = 26;
            end else if (i == 2 * total / 3) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            send_word(stim_words[i]);
        end
        i_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.error_count == 0 && tracker.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // hold off the output for a long stretch so the block backs up
    initial begin
        bit held;
        held = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && hold_from > 0 && words_sent >= hold_from) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) tracker.match_count(o_bit_count);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
